// ===== src/linear_probe_hash_table_assert.svh =====
// assertion macros for the linear probe hash table checker
// expects clk and arst_n in the scope where the macros are used
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define LPHT_ASSERT_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define LPHT_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== src/lpht_pkg.sv =====
// shared constants, codes and control types of the linear probe hash table
// no dependencies
package lpht_pkg;

	// table geometry
	localparam int TABLE_SIZE = 256;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

	// field widths
	localparam int KEY_W    = 31;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 8;
	localparam int PROBES_W = 9;

	// probe count saturation and the count reported after a full pass
	localparam int PROBES_MAX  = 511;
	localparam int PROBES_FULL = (TABLE_SIZE > PROBES_MAX) ? PROBES_MAX : TABLE_SIZE;

	// home slot by reciprocal multiply: quotient estimate is exact or one low
	localparam int HASH_SHIFT = KEY_W;
	localparam int RECIP_W    = KEY_W;
	localparam int PROD_W     = KEY_W + RECIP_W;
	localparam logic [RECIP_W-1:0] HASH_RECIP =
		RECIP_W'((64'd1 << HASH_SHIFT) / TABLE_SIZE);

	// request action codes
	localparam logic ACT_SEARCH = 1'b0;
	localparam logic ACT_INSERT = 1'b1;

	// response status codes
	typedef enum logic [STATUS_W-1:0] {
		STATUS_HIT  = 2'd0,
		STATUS_MISS = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_req;
		logic home;
		logic probe;
		logic clear;
		logic emit;
	} lpht_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clear_last;
		logic probe_done;
	} lpht_sts_t;

endpackage

// ===== src/lpht_req_if.sv =====
// request channel of the linear probe hash table
// depends on lpht_pkg for field widths
interface lpht_req_if;
	logic                                valid;
	logic                                ready;
	logic                                action;
	logic [lpht_pkg::KEY_W-1:0]          key;
	logic signed [lpht_pkg::DATA_W-1:0]  data;

	modport source (output valid, output action, output key, output data, input ready);
	modport sink (input valid, input action, input key, input data, output ready);
endinterface

// ===== src/lpht_rsp_if.sv =====
// response channel of the linear probe hash table
// depends on lpht_pkg for field widths
interface lpht_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [lpht_pkg::STATUS_W-1:0]       status;
	logic [lpht_pkg::SLOT_W-1:0]         slot;
	logic signed [lpht_pkg::DATA_W-1:0]  value;
	logic [lpht_pkg::PROBES_W-1:0]       probes;

	modport source (output valid, output status, output slot, output value, output probes,
		input ready);
	modport sink (input valid, input status, input slot, input value, input probes,
		output ready);
endinterface

// ===== src/lpht_ctrl.sv =====
// controller state machine of the linear probe hash table
// depends on lpht_pkg for command and status types
module lpht_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  lpht_pkg::lpht_sts_t sts,
	output lpht_pkg::lpht_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_REDUCE = 6'b000100,
		ST_HOME   = 6'b001000,
		ST_PROBE  = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_n;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	// handshake terms
	assign accept    = (state_q == ST_IDLE) && req_valid;
	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;

	// commands to the datapath
	assign cmd.load_req = accept;
	assign cmd.home     = (state_q == ST_HOME);
	assign cmd.probe    = (state_q == ST_PROBE);
	assign cmd.clear    = (state_q == ST_CLEAR);
	assign cmd.emit     = (state_q == ST_EMIT) && out_free;

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) state_n = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_n = ST_REDUCE;
			end
			ST_REDUCE: begin
				state_n = ST_HOME;
			end
			ST_HOME: begin
				state_n = ST_PROBE;
			end
			ST_PROBE: begin
				if (sts.probe_done) state_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_n = ST_IDLE;
			end
			default: begin
				state_n = ST_CLEAR;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/lpht_datapath.sv =====
// datapath of the linear probe hash table: home slot reduction, slot memory,
// probe compare and result registers; depends on lpht_pkg
module lpht_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lpht_pkg::lpht_cmd_t                  cmd,
	output lpht_pkg::lpht_sts_t                  sts,
	input  logic                                 action,
	input  logic [lpht_pkg::KEY_W-1:0]           key,
	input  logic signed [lpht_pkg::DATA_W-1:0]   data,
	output logic [lpht_pkg::STATUS_W-1:0]        status,
	output logic [lpht_pkg::SLOT_W-1:0]          slot,
	output logic signed [lpht_pkg::DATA_W-1:0]   value,
	output logic [lpht_pkg::PROBES_W-1:0]        probes
);

	localparam int IDX_W    = lpht_pkg::IDX_W;
	localparam int CNT_W    = lpht_pkg::CNT_W;
	localparam int KEY_W    = lpht_pkg::KEY_W;
	localparam int DATA_W   = lpht_pkg::DATA_W;
	localparam int PROBES_W = lpht_pkg::PROBES_W;
	localparam int SLOT_W   = lpht_pkg::SLOT_W;

	localparam logic [IDX_W:0]   SIZE_EXT = (IDX_W + 1)'(lpht_pkg::TABLE_SIZE);
	localparam logic [KEY_W-1:0] SIZE_KEY = KEY_W'(lpht_pkg::TABLE_SIZE);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(lpht_pkg::TABLE_SIZE - 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(lpht_pkg::TABLE_SIZE - 1);

	typedef struct packed {
		logic                      used;
		logic [KEY_W-1:0]          key;
		logic signed [DATA_W-1:0]  data;
	} entry_t;

	function automatic logic [PROBES_W-1:0] sat_probes(input logic [CNT_W-1:0] n);
		logic [31:0] wide;
		wide = 32'(n);
		if (wide > 32'(lpht_pkg::PROBES_MAX)) begin
			return PROBES_W'(lpht_pkg::PROBES_MAX);
		end
		return PROBES_W'(n);
	endfunction

	// slot memory
	entry_t mem [lpht_pkg::TABLE_SIZE];

	// request registers
	logic                          act_q;
	logic [KEY_W-1:0]              key_q;
	logic signed [DATA_W-1:0]      data_q;
	logic [lpht_pkg::PROD_W-1:0]   prod_s1;
	logic [IDX_W:0]                rem_s2;

	// probe registers
	logic [IDX_W-1:0]              rd_addr_q;
	entry_t                        rdata_q;
	logic [CNT_W-1:0]              cnt_q;

	// result and output registers
	lpht_pkg::status_t             res_status_q;
	logic [SLOT_W-1:0]             res_slot_q;
	logic signed [DATA_W-1:0]      res_value_q;
	logic [PROBES_W-1:0]           res_probes_q;
	lpht_pkg::status_t             out_status_q;
	logic [SLOT_W-1:0]             out_slot_q;
	logic signed [DATA_W-1:0]      out_value_q;
	logic [PROBES_W-1:0]           out_probes_q;

	// combinational terms
	logic [KEY_W-1:0]              quo;
	logic [KEY_W-1:0]              rem_full;
	logic [IDX_W-1:0]              home;
	logic [IDX_W-1:0]              addr_next;
	logic [IDX_W-1:0]              addr_n;
	logic [CNT_W-1:0]              cnt_inc;
	logic                          empty;
	logic                          hit;
	logic                          last;
	logic                          done;
	logic                          wr_en;
	entry_t                        wr_entry;

	// request capture and first reduction stage
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			act_q   <= action;
			key_q   <= key;
			data_q  <= data;
			prod_s1 <= key * lpht_pkg::HASH_RECIP;
		end
	end

	// remainder from the quotient estimate, below twice the table size
	assign quo      = prod_s1[lpht_pkg::HASH_SHIFT +: KEY_W];
	assign rem_full = key_q - KEY_W'(quo * SIZE_KEY);

	always_ff @(posedge clk) begin
		rem_s2 <= rem_full[IDX_W:0];
	end

	// final correction gives the home slot
	assign home = (rem_s2 >= SIZE_EXT) ? IDX_W'(rem_s2 - SIZE_EXT) : IDX_W'(rem_s2);

	// read address: home on probe start, then one slot forward with wrap
	assign addr_next = (rd_addr_q == IDX_LAST) ? '0 : rd_addr_q + 1'b1;

	always_comb begin
		addr_n = rd_addr_q;
		if (cmd.home) begin
			addr_n = home;
		end else if (cmd.probe || cmd.clear) begin
			addr_n = addr_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
		end else begin
			rd_addr_q <= addr_n;
		end
	end

	// slot examination
	assign cnt_inc = cnt_q + 1'b1;
	assign empty   = !rdata_q.used;
	assign hit     = rdata_q.used && (rdata_q.key == key_q) && (act_q == lpht_pkg::ACT_SEARCH);
	assign last    = rdata_q.used && !hit && (cnt_q == CNT_LAST);
	assign done    = empty || hit || last;

	assign sts.probe_done = done;
	assign sts.clear_last = (rd_addr_q == IDX_LAST);

	// count of occupied slots passed
	always_ff @(posedge clk) begin
		if (cmd.home) begin
			cnt_q <= '0;
		end else if (cmd.probe && !done) begin
			cnt_q <= cnt_inc;
		end
	end

	// result of the request
	always_ff @(posedge clk) begin
		if (cmd.probe && done) begin
			res_slot_q   <= '0;
			res_value_q  <= '0;
			res_probes_q <= sat_probes(cnt_q);
			if (hit) begin
				res_status_q <= lpht_pkg::STATUS_HIT;
				res_slot_q   <= SLOT_W'(rd_addr_q);
				res_value_q  <= rdata_q.data;
				res_probes_q <= sat_probes(cnt_inc);
			end else if (empty && (act_q == lpht_pkg::ACT_INSERT)) begin
				res_status_q <= lpht_pkg::STATUS_HIT;
				res_slot_q   <= SLOT_W'(rd_addr_q);
			end else if (empty) begin
				res_status_q <= lpht_pkg::STATUS_MISS;
			end else if (act_q == lpht_pkg::ACT_INSERT) begin
				res_status_q <= lpht_pkg::STATUS_FULL;
				res_probes_q <= PROBES_W'(lpht_pkg::PROBES_FULL);
			end else begin
				res_status_q <= lpht_pkg::STATUS_MISS;
				res_probes_q <= PROBES_W'(lpht_pkg::PROBES_FULL);
			end
		end
	end

	// memory write: clearing pass after reset, or store on insert
	assign wr_en = cmd.clear || (cmd.probe && empty && (act_q == lpht_pkg::ACT_INSERT));

	always_comb begin
		wr_entry = '0;
		if (!cmd.clear) begin
			wr_entry.used = 1'b1;
			wr_entry.key  = key_q;
			wr_entry.data = data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[rd_addr_q] <= wr_entry;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata_q <= mem[addr_n];
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_value_q  <= res_value_q;
			out_probes_q <= res_probes_q;
		end
	end

	assign status = out_status_q;
	assign slot   = out_slot_q;
	assign value  = out_value_q;
	assign probes = out_probes_q;

endmodule

// ===== src/linear_probe_hash_table.sv =====
// Linear probing hash table, open addressing over TABLE_SIZE slots.
// Channels: req (action, key, data) in, rsp (status, slot, value, probes) out,
// both valid/ready; a request moves at an edge with valid and ready high.
// A search walks forward from key mod TABLE_SIZE until the key or an empty
// slot; an insert stores in the first empty slot. One full pass at most.
// A result shows on rsp after the REDUCE and HOME states, the probe walk and
// the output register load; probes counts the slots read, less one if the
// walk stopped at an empty slot. A new request is taken only once the last
// has gone to the output register; the single read port of the slot memory
// reads one slot per cycle. Reset: the controller runs a clearing pass over
// all TABLE_SIZE slots of the slot memory; req.ready stays low during it.
// Stall: the result waits in the output register while rsp.ready is low;
// the next request is still taken and worked on, and it waits before its
// own result load until the output register is free.
// Depends on lpht_pkg, lpht_req_if, lpht_rsp_if, lpht_ctrl, lpht_datapath.
module linear_probe_hash_table (
	input  logic       clk,
	input  logic       arst_n,
	lpht_req_if.sink   req,
	lpht_rsp_if.source rsp
);

	lpht_pkg::lpht_cmd_t cmd;
	lpht_pkg::lpht_sts_t sts;

	// sequencing
	lpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// hashing, slot memory and results
	lpht_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.action (req.action),
		.key    (req.key),
		.data   (req.data),
		.status (rsp.status),
		.slot   (rsp.slot),
		.value  (rsp.value),
		.probes (rsp.probes)
	);

endmodule

// ===== src/lpht_checker.sv =====
// port-level checker of the linear probe hash table and its bind
// depends on lpht_pkg and linear_probe_hash_table_assert.svh
`include "linear_probe_hash_table_assert.svh"

module lpht_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 req_valid,
	input logic                                 req_ready,
	input logic                                 rsp_valid,
	input logic                                 rsp_ready,
	input logic [lpht_pkg::STATUS_W-1:0]        rsp_status,
	input logic [lpht_pkg::SLOT_W-1:0]          rsp_slot,
	input logic signed [lpht_pkg::DATA_W-1:0]   rsp_value,
	input logic [lpht_pkg::PROBES_W-1:0]        rsp_probes
);

	logic [1:0] pending_q;
	logic       req_fire;
	logic       rsp_fire;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	// requests taken and not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (req_fire && !rsp_fire) begin
			pending_q <= pending_q + 1'b1;
		end else if (rsp_fire && !req_fire) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	`LPHT_ASSERT_IMPLY(a_rsp_has_req, rsp_valid, pending_q != 2'd0, "response without request")
	`LPHT_ASSERT_IMPLY(a_req_depth, req_fire, pending_q <= 2'd1, "more than one request waiting")
	`LPHT_ASSERT_IMPLY(a_fail_clean, rsp_valid && (rsp_status != lpht_pkg::STATUS_HIT), (rsp_slot == '0) && (rsp_value == '0), "miss or full with slot or value set")
	`LPHT_ASSERT_IMPLY(a_full_pass, rsp_valid && (rsp_status == lpht_pkg::STATUS_FULL), rsp_probes == lpht_pkg::PROBES_W'(lpht_pkg::PROBES_FULL), "full without a whole pass")
	`LPHT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_slot) && $stable(rsp_value) && $stable(rsp_probes), "stalled response changed")

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_slot   (rsp.slot),
	.rsp_value  (rsp.value),
	.rsp_probes (rsp.probes)
);
